// ----- sv/log_record_deframer_crc32_defines.svh -----
// assertion macros shared by the deframer rtl
`ifndef LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define LRDC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define LRDC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define LRDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRDC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- sv/lrdc_pkg.sv -----
package lrdc_pkg;

	// depth of the result queue, at least two
	localparam int unsigned LRDC_RES_DEPTH = 4;

	// crc-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// index of the last header byte and of the last check byte
	localparam logic [3:0] HDR_LAST = 4'd15;
	localparam logic [1:0] CHK_LAST = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK,
		PH_HALTED
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_ACCEPT,
		KIND_MISMATCH,
		KIND_TRUNC
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [63:0] sequence_number;
		logic [31:0] record_type;
		logic [31:0] payload_length;
		logic        last_of_run;
	} result_t;

	// up to two results handed to the queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} res_push_t;

	// one byte through the reflected crc register
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- sv/lrdc_byte_if.sv -----
interface lrdc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ----- sv/lrdc_res_if.sv -----
interface lrdc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [63:0] sequence_number;
	logic [31:0] record_type;
	logic [31:0] payload_length;
	logic        last_of_run;

	modport source (
		output valid, output kind, output payload_byte, output sequence_number,
		output record_type, output payload_length, output last_of_run, input ready
	);
	modport sink (
		input valid, input kind, input payload_byte, input sequence_number,
		input record_type, input payload_length, input last_of_run, output ready
	);
endinterface

// ----- sv/log_record_deframer_crc32.sv -----
// Log record deframer with CRC-32 check.
// rx carries the log file one byte per request (data_byte, end_of_file marks
// the last byte of a file). tx carries results: payload bytes as they pass,
// then record accepted or CRC mismatch at the end of each record, and a
// truncation report when a file ends inside a record. Every result carries
// the header fields of its record; last_of_run flags the final result of a
// byte. A byte gives at most two results.
// Path: a byte taken from rx is held in the input register, parsed into the
// result queue once two entries are free, and offered on tx from there.
// Throughput: one byte per cycle while the queue has room; header CRC update,
// field capture and the compares sit between input register and result queue.
// The result queue holds ResDepth results; a byte is parsed only when two
// entries are free, so a stalled receiver fills the queue and then rx.ready
// falls. A byte giving two results pushes both at once; tx offers them in turn.
// After a mismatch bytes give no result until the file ends.
// Reset: header phase, empty queue, ready as soon as reset is released.
`include "log_record_deframer_crc32_defines.svh"

module log_record_deframer_crc32
	import lrdc_pkg::*;
#(
	parameter int unsigned ResDepth = LRDC_RES_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lrdc_byte_if.sink   rx,
	lrdc_res_if.source  tx
);

	localparam int unsigned PtrW = (ResDepth > 1) ? $clog2(ResDepth) : 1;
	localparam int unsigned CntW = $clog2(ResDepth + 1);

	res_push_t      push;
	logic           room;
	logic           pop;
	result_t        mem_q [ResDepth];
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] tail_q;
	logic [PtrW-1:0] tail_inc;
	logic [CntW-1:0] count_q;
	result_t        head_res;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(ResDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	lrdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.room   (room),
		.push   (push)
	);

	assign room     = count_q <= CntW'(ResDepth - 2);
	assign pop      = tx.valid && tx.ready;
	assign tail_inc = ptr_inc(tail_q);

	// result queue storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[tail_inc] <= push.r1;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (push.count == 2'd1) begin
				tail_q <= tail_inc;
			end else if (push.count == 2'd2) begin
				tail_q <= ptr_inc(tail_inc);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	// head of queue to the output channel
	assign head_res        = mem_q[head_q];
	assign tx.valid        = count_q != '0;
	assign tx.kind         = head_res.kind;
	assign tx.payload_byte = head_res.payload_byte;
	assign tx.sequence_number = head_res.sequence_number;
	assign tx.record_type  = head_res.record_type;
	assign tx.payload_length = head_res.payload_length;
	assign tx.last_of_run  = head_res.last_of_run;

	`LRDC_ASSERT(a_no_overflow, clk, arst_n,
		push.count != 2'd0 |-> count_q <= CntW'(ResDepth - 2),
		"result queue overflow")
	`LRDC_ASSERT(a_count_bound, clk, arst_n, count_q <= CntW'(ResDepth),
		"result queue level out of range")
	`LRDC_ASSERT(a_pair_order, clk, arst_n,
		push.count == 2'd2 |-> push.r1.kind == KIND_TRUNC && !push.r0.last_of_run,
		"second result of a byte is not a truncation report")

endmodule

// ----- sv/lrdc_core.sv -----
`include "log_record_deframer_crc32_defines.svh"

module lrdc_core
	import lrdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lrdc_byte_if.sink         rx,
	input  logic              room,
	output res_push_t         push
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// parser state
	phase_t      phase_q;
	logic [31:0] seen_q;
	logic [63:0] seq_q;
	logic [31:0] type_q;
	logic [31:0] len_q;
	logic [31:0] crc_q;
	logic [31:0] check_q;

	// values after the byte itself, before end of file handling
	phase_t      phase_st;
	logic [31:0] seen_st;
	logic [63:0] seq_st;
	logic [31:0] type_st;
	logic [31:0] len_st;
	logic [31:0] crc_st;
	logic [31:0] check_st;
	logic        done_st;
	logic        prim_st;
	kind_t       prim_kind;

	// next state
	phase_t      phase_n;
	logic [31:0] seen_n;
	logic [63:0] seq_n;
	logic [31:0] type_n;
	logic [31:0] len_n;
	logic [31:0] crc_n;
	logic [31:0] check_n;

	logic        fire;
	logic        trunc;
	logic [31:0] seen_inc;
	logic [31:0] crc_upd;
	logic [31:0] check_shift;
	logic [3:0]  hdr_idx;
	result_t     res_prim;
	result_t     res_trunc;

	assign fire        = valid_s1 && room;
	assign rx.ready    = !valid_s1 || room;
	assign seen_inc    = seen_q + 32'd1;
	assign crc_upd     = crc32_byte(crc_q, byte_s1);
	assign check_shift = {check_q[23:0], byte_s1};
	assign hdr_idx     = seen_q[3:0];

	// input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			eof_s1  <= rx.end_of_file;
		end
	end

	// effect of the byte in the current phase
	always_comb begin
		phase_st  = phase_q;
		seen_st   = seen_q;
		seq_st    = seq_q;
		type_st   = type_q;
		len_st    = len_q;
		crc_st    = crc_q;
		check_st  = check_q;
		done_st   = 1'b0;
		prim_st   = 1'b0;
		prim_kind = KIND_PAYLOAD;
		unique case (phase_q)
			PH_HEADER: begin
				crc_st = crc_upd;
				if (!hdr_idx[3]) begin
					seq_st[{~hdr_idx[2:0], 3'b000} +: 8] = byte_s1;
				end else if (!hdr_idx[2]) begin
					type_st[{~hdr_idx[1:0], 3'b000} +: 8] = byte_s1;
				end else begin
					len_st[{~hdr_idx[1:0], 3'b000} +: 8] = byte_s1;
				end
				seen_st = seen_inc;
				if (hdr_idx == HDR_LAST) begin
					seen_st  = '0;
					phase_st = (len_st == 32'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				crc_st    = crc_upd;
				prim_st   = 1'b1;
				prim_kind = KIND_PAYLOAD;
				seen_st   = seen_inc;
				if (seen_inc == len_q) begin
					seen_st  = '0;
					phase_st = PH_CHECK;
				end
			end
			PH_CHECK: begin
				check_st = check_shift;
				seen_st  = seen_inc;
				if (seen_q[1:0] == CHK_LAST) begin
					done_st   = 1'b1;
					prim_st   = 1'b1;
					seen_st   = '0;
					if (~crc_q == check_shift) begin
						prim_kind = KIND_ACCEPT;
						phase_st  = PH_HEADER;
					end else begin
						prim_kind = KIND_MISMATCH;
						phase_st  = PH_HALTED;
					end
				end
			end
			PH_HALTED: begin
			end
			default: begin
			end
		endcase
	end

	// file end inside a record is reported as truncation
	assign trunc = eof_s1 && ((phase_st == PH_PAYLOAD) || (phase_st == PH_CHECK) ||
		(phase_st == PH_HEADER && seen_st != 32'd0));

	// next state: record fields cleared after a check word or at file end, header phase at file end
	always_comb begin
		phase_n = phase_st;
		seen_n  = seen_st;
		seq_n   = seq_st;
		type_n  = type_st;
		len_n   = len_st;
		crc_n   = crc_st;
		check_n = check_st;
		if (done_st || eof_s1) begin
			seen_n  = '0;
			seq_n   = '0;
			type_n  = '0;
			len_n   = '0;
			crc_n   = CRC_INIT;
			check_n = '0;
		end
		if (eof_s1) begin
			phase_n = PH_HEADER;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			seen_q  <= '0;
			seq_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			crc_q   <= CRC_INIT;
			check_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			seen_q  <= seen_n;
			seq_q   <= seq_n;
			type_q  <= type_n;
			len_q   <= len_n;
			crc_q   <= crc_n;
			check_q <= check_n;
		end
	end

	// results of this byte
	always_comb begin
		res_prim.kind            = prim_kind;
		res_prim.payload_byte    = (prim_kind == KIND_PAYLOAD) ? byte_s1 : 8'd0;
		res_prim.sequence_number = seq_st;
		res_prim.record_type     = type_st;
		res_prim.payload_length  = len_st;
		res_prim.last_of_run     = !trunc;

		res_trunc.kind            = KIND_TRUNC;
		res_trunc.payload_byte    = 8'd0;
		res_trunc.sequence_number = seq_st;
		res_trunc.record_type     = type_st;
		res_trunc.payload_length  = len_st;
		res_trunc.last_of_run     = 1'b1;

		push.r0    = prim_st ? res_prim : res_trunc;
		push.r1    = res_trunc;
		push.count = fire ? ({1'b0, prim_st} + {1'b0, trunc}) : 2'd0;
	end

	`LRDC_ASSERT(a_hdr_count, clk, arst_n, phase_q == PH_HEADER |-> seen_q < 32'd16,
		"header byte count out of range")
	`LRDC_ASSERT(a_chk_count, clk, arst_n, phase_q == PH_CHECK |-> seen_q < 32'd4,
		"check byte count out of range")
	`LRDC_ASSERT_NEVER(a_halted_quiet, clk, arst_n,
		fire && phase_q == PH_HALTED && push.count != 2'd0,
		"result produced while halted")

endmodule
